// ===== rtl/kac_pkg.sv =====
// shared types, codes and helpers of the keypad alarm controller
package kac_pkg;

  // request op codes
  localparam logic [2:0] OP_KEY   = 3'd0;
  localparam logic [2:0] OP_SOUND = 3'd1;
  localparam logic [2:0] OP_PROX  = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_PING  = 3'd4;

  // panel mode codes
  localparam logic [1:0] MODE_SET_CODE  = 2'd0;
  localparam logic [1:0] MODE_UNARMED   = 2'd1;
  localparam logic [1:0] MODE_ARMED     = 2'd2;
  localparam logic [1:0] MODE_TRIGGERED = 2'd3;

  // status codes reported with each result
  localparam logic [3:0] ST_NONE     = 4'd0;
  localparam logic [3:0] ST_DIGIT    = 4'd1;
  localparam logic [3:0] ST_STORED   = 4'd2;
  localparam logic [3:0] ST_START    = 4'd3;
  localparam logic [3:0] ST_ARMED    = 4'd4;
  localparam logic [3:0] ST_DISARMED = 4'd5;
  localparam logic [3:0] ST_WRONG    = 4'd6;
  localparam logic [3:0] ST_TRIG     = 4'd7;
  localparam logic [3:0] ST_DARK     = 4'd8;

  // key A sits at the end of the top row
  localparam logic [1:0] KEY_A_ROW = 2'd0;
  localparam logic [1:0] KEY_A_COL = 2'd3;

  // idle timeout out of reset, 10 s of millisecond ticks
  localparam logic [15:0] IDLE_RESET = 16'd10000;

  // control flags of the panel
  typedef struct packed {
    logic [1:0] mode;
    logic       buzz;
    logic       led;
    logic       mic;
    logic       disp;
    logic       entering;
  } kac_ctl_t;

  // decoded keypad key
  typedef struct packed {
    logic       valid;
    logic [3:0] digit;
  } kac_key_t;

  // layout 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
  function automatic kac_key_t key_digit(input logic [1:0] row, input logic [1:0] col);
    kac_key_t k;
    k.valid = 1'b0;
    k.digit = 4'd0;
    if (col != 2'd3) begin
      if (row != 2'd3) begin
        k.valid = 1'b1;
        k.digit = ({2'b00, row} * 4'd3) + {2'b00, col} + 4'd1;
      end else if (col == 2'd1) begin
        k.valid = 1'b1;
        k.digit = 4'd0;
      end
    end
    return k;
  endfunction

endpackage

// ===== rtl/kac_if.sv =====
// request and result channel interfaces of the keypad alarm controller

// event request channel
interface kac_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [1:0] key_row;
  logic [1:0] key_col;
  logic       echo_high;

  modport source (output valid, output op, output key_row, output key_col,
                  output echo_high, input ready);
  modport sink (input valid, input op, input key_row, input key_col,
                input echo_high, output ready);
endinterface

// result channel
interface kac_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode_now;
  logic       buzzer_on;
  logic       leds_on;
  logic       mic_enabled;
  logic       display_lit;
  logic       entry_active;
  logic [1:0] digits_taken;
  logic [3:0] status;

  modport source (output valid, output mode_now, output buzzer_on, output leds_on,
                  output mic_enabled, output display_lit, output entry_active,
                  output digits_taken, output status, input ready);
  modport sink (input valid, input mode_now, input buzzer_on, input leds_on,
                input mic_enabled, input display_lit, input entry_active,
                input digits_taken, input status, output ready);
endinterface

// ===== rtl/kac_core.sv =====
// next-state logic of the alarm panel for one event request
module kac_core
  import kac_pkg::*;
#(
  parameter int CODE_DIGITS = 4,
  parameter int PosW        = 2
) (
  input  logic [2:0]      op_i,
  input  logic [1:0]      key_row_i,
  input  logic [1:0]      key_col_i,
  input  logic            echo_high_i,
  input  logic [15:0]     idle_limit_i,
  input  kac_ctl_t        ctl_q_i,
  input  logic [PosW-1:0] pos_q_i,
  input  logic [15:0]     cnt_q_i,
  input  logic [3:0]      stored_q_i  [CODE_DIGITS],
  input  logic [3:0]      entered_q_i [CODE_DIGITS],
  output kac_ctl_t        ctl_d_o,
  output logic [PosW-1:0] pos_d_o,
  output logic [15:0]     cnt_d_o,
  output logic            stored_we_o,
  output logic            entered_we_o,
  output logic [3:0]      digit_o,
  output logic [3:0]      status_o
);

  kac_key_t        key;
  logic            last_pos;
  logic            same;
  logic [PosW-1:0] pos_inc;

  // key decode and entry position step
  assign key      = key_digit(key_row_i, key_col_i);
  assign digit_o  = key.digit;
  assign last_pos = (pos_q_i == PosW'(CODE_DIGITS - 1));
  assign pos_inc  = last_pos ? '0 : pos_q_i + 1'b1;

  // code compare, the final digit comes straight from the key
  always_comb begin
    same = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (i == CODE_DIGITS - 1) begin
        if (key.digit != stored_q_i[i]) same = 1'b0;
      end else begin
        if (entered_q_i[i] != stored_q_i[i]) same = 1'b0;
      end
    end
  end

  // mode rules per op
  always_comb begin
    ctl_d_o      = ctl_q_i;
    pos_d_o      = pos_q_i;
    cnt_d_o      = cnt_q_i;
    stored_we_o  = 1'b0;
    entered_we_o = 1'b0;
    status_o     = ST_NONE;
    case (op_i)
      OP_KEY: begin
        ctl_d_o.disp = 1'b1;
        cnt_d_o      = idle_limit_i;
        if (ctl_q_i.mode == MODE_SET_CODE) begin
          if (key.valid) begin
            stored_we_o = 1'b1;
            pos_d_o     = pos_inc;
            if (last_pos) begin
              ctl_d_o.mode = MODE_UNARMED;
              status_o     = ST_STORED;
            end else begin
              status_o = ST_DIGIT;
            end
          end
        end else if (!ctl_q_i.entering) begin
          if (key_row_i == KEY_A_ROW && key_col_i == KEY_A_COL) begin
            ctl_d_o.entering = 1'b1;
            status_o         = ST_START;
          end
        end else if (key.valid) begin
          entered_we_o = 1'b1;
          pos_d_o      = pos_inc;
          if (!last_pos) begin
            status_o = ST_DIGIT;
          end else begin
            ctl_d_o.entering = 1'b0;
            if (!same) begin
              status_o = ST_WRONG;
            end else if (ctl_q_i.mode == MODE_UNARMED) begin
              ctl_d_o.mode = MODE_ARMED;
              ctl_d_o.mic  = 1'b1;
              status_o     = ST_ARMED;
            end else begin
              if (ctl_q_i.mode == MODE_TRIGGERED) begin
                ctl_d_o.buzz = 1'b0;
                ctl_d_o.led  = 1'b0;
              end
              ctl_d_o.mode = MODE_UNARMED;
              status_o     = ST_DISARMED;
            end
          end
        end
      end
      OP_SOUND, OP_PROX: begin
        if (ctl_q_i.mode == MODE_ARMED &&
            ((op_i == OP_SOUND && ctl_q_i.mic) || (op_i == OP_PROX && !echo_high_i))) begin
          ctl_d_o.mode     = MODE_TRIGGERED;
          ctl_d_o.led      = 1'b1;
          ctl_d_o.buzz     = 1'b1;
          ctl_d_o.mic      = 1'b0;
          ctl_d_o.entering = 1'b0;
          pos_d_o          = '0;
          status_o         = ST_TRIG;
        end
      end
      OP_TICK: begin
        if (cnt_q_i != 16'd0) begin
          cnt_d_o = cnt_q_i - 16'd1;
          if (cnt_q_i == 16'd1 && ctl_q_i.disp) begin
            ctl_d_o.disp     = 1'b0;
            ctl_d_o.entering = 1'b0;
            pos_d_o          = '0;
            status_o         = ST_DARK;
          end
        end
      end
      OP_PING: begin
        if (!echo_high_i && ctl_q_i.mode == MODE_TRIGGERED) ctl_d_o.led = ~ctl_q_i.led;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/keypad_alarm_controller_top.sv =====
// keypad alarm controller top level: panel state, code stores and result register
//
// Usage: event requests arrive on evt_i (key press, sound, proximity check,
// millisecond tick, sensor ping); every accepted request gives exactly one
// result on res_o with the panel state after that event and a status code.
// Idle timeout: user writes cfg_we_i / cfg_wdata_i only while idle, not enforced.
// Latency: the result is valid in the cycle after the request is accepted.
// Throughput: one request per cycle; the panel state and the result are the
// same set of registers, updated by one pass of the mode logic in kac_core.
// Stall: while a result waits and res_o.ready is low, evt_i.ready is low and
// the state holds; a new request is taken in the same cycle the result goes.
// Reset: set-code mode, no entry, display lit, buzzer, LEDs and microphone
// off, idle timer and idle limit at 10000 ticks, no result pending. The
// stored and entered codes are not cleared; they are written before use.
module keypad_alarm_controller_top
  import kac_pkg::*;
#(
  parameter int CODE_DIGITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  kac_evt_if.sink     evt_i,
  kac_res_if.source   res_o
);

  localparam int PosW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  kac_ctl_t        ctl_q, ctl_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     cnt_q, cnt_d;
  logic [15:0]     idle_limit_q;
  logic [3:0]      stored_q  [CODE_DIGITS];
  logic [3:0]      entered_q [CODE_DIGITS];
  logic [3:0]      status_q, status_d;
  logic            valid_q;
  logic            stored_we, entered_we;
  logic [3:0]      digit;
  logic            accept;
  logic [PosW+1:0] pos_ext;

  // handshake
  assign evt_i.ready = !valid_q || res_o.ready;
  assign accept      = evt_i.valid && evt_i.ready;

  // mode logic
  kac_core #(
    .CODE_DIGITS (CODE_DIGITS),
    .PosW        (PosW)
  ) u_core (
    .op_i         (evt_i.op),
    .key_row_i    (evt_i.key_row),
    .key_col_i    (evt_i.key_col),
    .echo_high_i  (evt_i.echo_high),
    .idle_limit_i (idle_limit_q),
    .ctl_q_i      (ctl_q),
    .pos_q_i      (pos_q),
    .cnt_q_i      (cnt_q),
    .stored_q_i   (stored_q),
    .entered_q_i  (entered_q),
    .ctl_d_o      (ctl_d),
    .pos_d_o      (pos_d),
    .cnt_d_o      (cnt_d),
    .stored_we_o  (stored_we),
    .entered_we_o (entered_we),
    .digit_o      (digit),
    .status_o     (status_d)
  );

  // idle limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q <= IDLE_RESET;
    end else if (cfg_we_i) begin
      idle_limit_q <= cfg_wdata_i;
    end
  end

  // panel state, doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= '{mode: MODE_SET_CODE, disp: 1'b1, default: 1'b0};
      pos_q   <= '0;
      cnt_q   <= IDLE_RESET;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        ctl_q <= ctl_d;
        pos_q <= pos_d;
        cnt_q <= cnt_d;
      end
      if (accept) begin
        valid_q <= 1'b1;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // status and digit stores, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        if (pos_q == PosW'(i)) begin
          if (stored_we) stored_q[i] <= digit;
          if (entered_we) entered_q[i] <= digit;
        end
      end
    end
  end

  // result fields
  assign pos_ext            = {2'b00, pos_q};
  assign res_o.valid        = valid_q;
  assign res_o.mode_now     = ctl_q.mode;
  assign res_o.buzzer_on    = ctl_q.buzz;
  assign res_o.leds_on      = ctl_q.led;
  assign res_o.mic_enabled  = ctl_q.mic;
  assign res_o.display_lit  = ctl_q.disp;
  assign res_o.entry_active = ctl_q.entering;
  assign res_o.digits_taken = pos_ext[1:0];
  assign res_o.status       = status_q;

endmodule

// ===== rtl/kac_checker.sv =====
// port-level assertions of the keypad alarm controller and their bind
module kac_checker
  import kac_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] mode_now_i,
  input logic       buzzer_on_i,
  input logic       mic_enabled_i
);

  // a pending result stays until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // every accepted request gives a result in the next cycle
  a_req_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted request gave no result");

  // no result without a request
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_i) && !out_valid_i |=> !out_valid_i)
    else $error("result appeared without a request");

  // triggered mode always drives the buzzer with the microphone gated off
  a_trig_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mode_now_i == MODE_TRIGGERED |-> buzzer_on_i && !mic_enabled_i)
    else $error("triggered mode with wrong buzzer or microphone level");

endmodule

bind keypad_alarm_controller_top kac_checker u_kac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (evt_i.valid),
  .in_ready_i    (evt_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .mode_now_i    (res_o.mode_now),
  .buzzer_on_i   (res_o.buzzer_on),
  .mic_enabled_i (res_o.mic_enabled)
);

// ===== bench/keypad_alarm_controller_checker.sv =====
// checker of the keypad alarm controller: tracks the panel per request and compares results
module keypad_alarm_controller_checker
  import kac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  kac_evt_if          evt,
  kac_res_if          res,
  output int          fail_count,
  output int          pending
);

  localparam int DIGITS = 4;

  // one expected result, laid out as the result channel
  typedef struct packed {
    logic [1:0] mode;
    logic       buzz;
    logic       led;
    logic       mic;
    logic       disp;
    logic       entry;
    logic [1:0] digits;
    logic [3:0] status;
  } panel_res_t;

  panel_res_t panel_results_q[$];

  // tracked panel state
  logic [1:0]  mode;
  logic [3:0]  stored_code[DIGITS];
  logic [3:0]  entered_code[DIGITS];
  int          pos;
  logic        entering;
  logic        disp;
  logic        buzz;
  logic        led;
  logic        mic;
  logic [15:0] idle_cnt;
  logic [15:0] idle_lim;

  // digit value of a key, -1 for letters, star and hash
  function automatic int key_value(logic [1:0] row, logic [1:0] col);
    if (col == 2'd3) return -1;
    if (row != 2'd3) return int'(row) * 3 + int'(col) + 1;
    return (col == 2'd1) ? 0 : -1;
  endfunction

  // alarm goes off: buzzer and leds on, microphone gated, entry dropped
  function automatic void trip_alarm();
    mode     = MODE_TRIGGERED;
    led      = 1'b1;
    buzz     = 1'b1;
    mic      = 1'b0;
    pos      = 0;
    entering = 1'b0;
  endfunction

  // key press: wakes display, key A starts entry, fills stored or entered code, checks it
  function automatic logic [3:0] take_key(logic [1:0] row, logic [1:0] col);
    int   d;
    logic same;
    d        = key_value(row, col);
    same     = 1'b1;
    disp     = 1'b1;
    idle_cnt = idle_lim;
    if (mode == MODE_SET_CODE) begin
      if (d < 0) return ST_NONE;
      if (pos >= DIGITS) pos = 0;
      stored_code[pos] = 4'(d);
      pos++;
      if (pos < DIGITS) return ST_DIGIT;
      pos  = 0;
      mode = MODE_UNARMED;
      return ST_STORED;
    end
    if (!entering) begin
      if (row == KEY_A_ROW && col == KEY_A_COL) begin
        entering = 1'b1;
        return ST_START;
      end
      return ST_NONE;
    end
    if (d < 0) return ST_NONE;
    if (pos >= DIGITS) pos = 0;
    entered_code[pos] = 4'(d);
    pos++;
    if (pos < DIGITS) return ST_DIGIT;
    pos      = 0;
    entering = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (entered_code[i] != stored_code[i]) same = 1'b0;
    end
    if (!same) return ST_WRONG;
    if (mode == MODE_UNARMED) begin
      mode = MODE_ARMED;
      mic  = 1'b1;
      return ST_ARMED;
    end
    if (mode == MODE_TRIGGERED) begin
      buzz = 1'b0;
      led  = 1'b0;
    end
    mode = MODE_UNARMED;
    return ST_DISARMED;
  endfunction

  // advance the panel by one request and give the resulting panel view
  function automatic panel_res_t panel_after(logic [2:0] op, logic [1:0] row,
                                             logic [1:0] col, logic echo);
    panel_res_t r;
    logic [3:0] st;
    st = ST_NONE;
    case (op)
      OP_KEY: begin
        st = take_key(row, col);
      end
      OP_SOUND: begin
        if (mic && mode == MODE_ARMED) begin
          trip_alarm();
          st = ST_TRIG;
        end
      end
      OP_PROX: begin
        if (mode == MODE_ARMED && !echo) begin
          trip_alarm();
          st = ST_TRIG;
        end
      end
      OP_TICK: begin
        // one-shot idle timer, fires on the tick that reaches zero
        if (idle_cnt != 16'd0) begin
          idle_cnt--;
          if (idle_cnt == 16'd0 && disp) begin
            disp     = 1'b0;
            pos      = 0;
            entering = 1'b0;
            st       = ST_DARK;
          end
        end
      end
      OP_PING: begin
        if (!echo && mode == MODE_TRIGGERED) led = !led;
      end
      default: ;
    endcase
    r.mode   = mode;
    r.buzz   = buzz;
    r.led    = led;
    r.mic    = mic;
    r.disp   = disp;
    r.entry  = entering;
    r.digits = 2'(pos);
    r.status = st;
    return r;
  endfunction

  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // compare results with the oldest prediction, then predict for new requests
  always @(posedge clk_i or negedge rst_ni) begin
    panel_res_t want;
    if (!rst_ni) begin
      mode       = MODE_SET_CODE;
      pos        = 0;
      entering   = 1'b0;
      disp       = 1'b1;
      buzz       = 1'b0;
      led        = 1'b0;
      mic        = 1'b0;
      idle_cnt   = IDLE_RESET;
      idle_lim   = IDLE_RESET;
      fail_count = 0;
      panel_results_q.delete();
      pending   <= 0;
    end else begin
      if (cfg_we_i) idle_lim = cfg_wdata_i;
      if (res.valid && res.ready) begin
        if (panel_results_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = panel_results_q.pop_front();
          check_field("mode_now", 4'(want.mode), 4'(res.mode_now));
          check_field("buzzer_on", 4'(want.buzz), 4'(res.buzzer_on));
          check_field("leds_on", 4'(want.led), 4'(res.leds_on));
          check_field("mic_enabled", 4'(want.mic), 4'(res.mic_enabled));
          check_field("display_lit", 4'(want.disp), 4'(res.display_lit));
          check_field("entry_active", 4'(want.entry), 4'(res.entry_active));
          check_field("digits_taken", 4'(want.digits), 4'(res.digits_taken));
          check_field("status", want.status, res.status);
        end
      end
      if (evt.valid && evt.ready) begin
        panel_results_q.push_back(panel_after(evt.op, evt.key_row, evt.key_col,
                                              evt.echo_high));
      end
      pending <= panel_results_q.size();
    end
  end

endmodule

// ===== bench/keypad_alarm_controller_top_tb.sv =====
// testbench top of the keypad alarm controller: clock, reset, requests, stalls and verdict
module keypad_alarm_controller_top_tb;
  import kac_pkg::*;

  localparam int RANDOM_REQS = 1950;
  localparam int SEG_REQS    = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  int          fail_count;
  int          pending;
  int          req_count;
  int          idle_pct;
  int          stall_pct;
  logic [3:0]  panel_code[4];

  kac_evt_if evt();
  kac_res_if res();

  keypad_alarm_controller_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .evt_i      (evt),
    .res_o      (res)
  );

  keypad_alarm_controller_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .evt        (evt),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    res.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // overall run limit
  initial begin
    #3000000;
    $display("[keypad_alarm_controller_top] ERROR");
    $finish;
  end

  // one request, with random idle cycles ahead of it
  task automatic send_req(logic [2:0] op, logic [1:0] row, logic [1:0] col, logic echo);
    while ($urandom_range(0, 99) < idle_pct) begin
      evt.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt.valid     <= 1'b1;
    evt.op        <= op;
    evt.key_row   <= row;
    evt.key_col   <= col;
    evt.echo_high <= echo;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
    req_count++;
  endtask

  task automatic press(logic [1:0] row, logic [1:0] col);
    send_req(OP_KEY, row, col, 1'($urandom_range(0, 1)));
  endtask

  task automatic press_digit(int d);
    if (d == 0) press(2'd3, 2'd1);
    else press(2'((d - 1) / 3), 2'((d - 1) % 3));
  endtask

  // letters, star and hash
  task automatic press_other();
    case ($urandom_range(0, 5))
      0: press(KEY_A_ROW, KEY_A_COL);
      1: press(2'd1, 2'd3);
      2: press(2'd2, 2'd3);
      3: press(2'd3, 2'd3);
      4: press(2'd3, 2'd0);
      default: press(2'd3, 2'd2);
    endcase
  endtask

  // key A then four digits, right code or one digit off, maybe with stray keys
  task automatic enter_code(bit right, bit noisy);
    int bad_pos;
    bad_pos = $urandom_range(0, 3);
    press(KEY_A_ROW, KEY_A_COL);
    for (int i = 0; i < 4; i++) begin
      if (noisy && $urandom_range(0, 3) == 0) press_other();
      if (!right && i == bad_pos) press_digit((int'(panel_code[i]) + 1) % 10);
      else press_digit(int'(panel_code[i]));
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    evt.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_idle_limit(logic [15:0] ticks);
    drain();
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mixed traffic, weighted towards full code entries
  task automatic random_traffic(int last_req);
    int pick;
    while (req_count < last_req) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        enter_code($urandom_range(0, 4) != 0, $urandom_range(0, 3) == 0);
      end else if (pick < 48) begin
        send_req(OP_SOUND, 2'($urandom), 2'($urandom), 1'($urandom));
      end else if (pick < 58) begin
        send_req(OP_PROX, 2'($urandom), 2'($urandom), $urandom_range(0, 9) < 3);
      end else if (pick < 73) begin
        repeat ($urandom_range(1, 8)) send_req(OP_TICK, 2'($urandom), 2'($urandom),
                                               1'($urandom));
      end else if (pick < 84) begin
        send_req(OP_PING, 2'($urandom), 2'($urandom), $urandom_range(0, 9) < 4);
      end else if (pick < 95) begin
        press(2'($urandom), 2'($urandom));
      end else begin
        send_req(3'($urandom_range(5, 7)), 2'($urandom), 2'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    int seg;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 16'd0;
    evt.valid     <= 1'b0;
    evt.op        <= OP_KEY;
    evt.key_row   <= 2'd0;
    evt.key_col   <= 2'd0;
    evt.echo_high <= 1'b0;
    req_count      = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    panel_code[0]  = 4'd0;
    panel_code[1]  = 4'd9;
    panel_code[2]  = 4'($urandom_range(0, 9));
    panel_code[3]  = 4'($urandom_range(0, 9));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unused op, set code, entry, wrong code, arm, trigger, disarm
    send_req(3'd7, 2'd3, 2'd3, 1'b1);
    press(KEY_A_ROW, KEY_A_COL);
    for (int i = 0; i < 4; i++) press_digit(int'(panel_code[i]));
    press_digit(5);
    send_req(OP_SOUND, 2'd0, 2'd0, 1'b0);
    press(KEY_A_ROW, KEY_A_COL);
    press(KEY_A_ROW, KEY_A_COL);
    for (int i = 0; i < 4; i++) begin
      if (i == 3) press_digit((int'(panel_code[i]) + 1) % 10);
      else press_digit(int'(panel_code[i]));
    end
    enter_code(1'b1, 1'b0);
    send_req(OP_PROX, 2'd0, 2'd0, 1'b1);
    send_req(OP_SOUND, 2'd3, 2'd3, 1'b1);
    send_req(OP_PING, 2'd0, 2'd0, 1'b0);
    send_req(OP_PING, 2'd0, 2'd0, 1'b1);
    send_req(OP_SOUND, 2'd0, 2'd0, 1'b0);
    enter_code(1'b1, 1'b0);

    // random segments, each with its own idle limit and idling pattern
    seg = 0;
    while (req_count < RANDOM_REQS + 30) begin
      case (seg % 6)
        0: write_idle_limit(16'd1);
        1: write_idle_limit(16'd65535);
        2: write_idle_limit(IDLE_RESET);
        3: write_idle_limit(16'($urandom_range(1, 65535)));
        default: write_idle_limit(16'($urandom_range(2, 12)));
      endcase
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      random_traffic(req_count + SEG_REQS);
      seg++;
    end

    drain();
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[keypad_alarm_controller_top] OK");
    end else begin
      $display("[keypad_alarm_controller_top] ERROR");
    end
    $finish;
  end

endmodule
